[src/sdfh_pkg.sv]
// ----------------------------------------------------------------------------
// sdfh_pkg: shared types for the smoothed Heaviside pipeline
// Widths of the fixed-point fields and the divider stage record.
// ----------------------------------------------------------------------------
package sdfh_pkg;

    localparam int DW     = 32;     // width of one Q16.16 word
    localparam int FB     = 16;     // fraction bits
    localparam int REGW   = 31;     // configuration register width
    localparam int DENW   = 48;     // denominator width
    localparam int QBITS  = 33;     // quotient bits produced by the divider

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_SPACING_H   = 2'd0;
    localparam cfg_index_t REG_INV_TWO_H   = 2'd1;
    localparam cfg_index_t REG_HALF_H_SQ   = 2'd2;

    // Everything the final stage needs besides the two quotients.
    typedef struct packed {
        logic                 far;
        logic                 far_inside;
        logic                 neg_h;
        logic                 neg_d;
        logic signed [DW-1:0] prior;
        logic signed [DW-1:0] gu_x;
        logic signed [DW-1:0] gu_y;
        logic signed [DW-1:0] gu_z;
    } side_t;

    typedef struct packed {
        logic [DENW-1:0]  den;
        logic [DENW-1:0]  rem_h;
        logic [DENW-1:0]  rem_d;
        logic [QBITS-1:0] low_h;
        logic [QBITS-1:0] low_d;
        logic [QBITS-1:0] q_h;
        logic [QBITS-1:0] q_d;
        logic             ovf_h;
        logic             ovf_d;
        side_t            side;
    } div_stage_t;

endpackage

[src/sdf_to_smoothed_heaviside.sv]
// ----------------------------------------------------------------------------
// sdf_to_smoothed_heaviside: smoothed indicator and surface weight per cell
// Gradients, dot products and two pipelined divisions over a 41-stage pipe.
//
//   channel   dir   payload
//   s_*       in    tdata: sdf_center, dist_+x, -x, +y, -y, +z, -z, prior_chi
//   m_*       out   tdata: chi_value, merged_chi, delta_weight, grad_x/y/z
//                   tuser: surface_valid
//   cfg_*     in    write enable, register index, 31-bit data
//
// One beat is taken every cycle while the output is not stalled; most of the
// depth lies in the 33 quotient-bit stages of the divider.
// The whole pipe advances together, so a stall on m_tready holds every stage.
// Reset clears valid bits and loads h = 1.0, 1/(2h) = 0.5, 0.5h^2 = 0.5.
// ----------------------------------------------------------------------------
module sdf_to_smoothed_heaviside
    import sdfh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [255:0]     s_tdata,   // sdf_center, dist_plus_x, dist_minus_x,
                                        // dist_plus_y, dist_minus_y, dist_plus_z,
                                        // dist_minus_z, prior_chi (32 bits each)
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [191:0]     m_tdata,   // chi_value, merged_chi, delta_weight,
                                        // grad_x, grad_y, grad_z (32 bits each)
    output logic             m_tuser,   // surface_valid
    input  logic             cfg_we,
    input  cfg_index_t       cfg_index,
    input  logic [REGW-1:0]  cfg_data
);

    typedef struct {
        logic                  far;
        logic                  far_inside;
        logic signed [DW-1:0]  prior;
        logic signed [DW:0]    dd [3];
        logic signed [DW:0]    di [3];
        logic signed [2:0]     gh [3];
    } s1_t;

    typedef struct {
        logic                  far;
        logic                  far_inside;
        logic signed [DW-1:0]  prior;
        logic signed [63:0]    pg [3];
        logic signed [63:0]    pi [3];
        logic signed [2:0]     gh [3];
    } s2_t;

    typedef struct {
        logic                  far;
        logic                  far_inside;
        logic signed [DW-1:0]  prior;
        logic signed [DW-1:0]  gu [3];
        logic signed [DW-1:0]  gi [3];
        logic signed [2:0]     gh [3];
    } s3_t;

    typedef struct {
        logic                  far;
        logic                  far_inside;
        logic signed [DW-1:0]  prior;
        logic signed [DW-1:0]  gu [3];
        logic signed [63:0]    puu [3];
        logic signed [63:0]    pih [3];
        logic signed [34:0]    phd [3];
    } s4_t;

    typedef struct {
        logic                  far;
        logic                  far_inside;
        logic signed [DW-1:0]  prior;
        logic signed [DW-1:0]  gu [3];
        logic [DENW-1:0]       den;
        logic signed [DENW:0]  num_h;
        logic signed [34:0]    num_d;
    } s5_t;

    localparam logic [QBITS-1:0] Q_MAX_POS = {2'b00, {(DW-1){1'b1}}};
    localparam logic [QBITS-1:0] Q_MAX_NEG = {2'b01, {(DW-1){1'b0}}};
    localparam logic [DW-1:0]    ONE_FIX   = DW'(1) << FB;
    localparam logic [DW-1:0]    SAT_POS   = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0]    SAT_NEG   = {1'b1, {(DW-1){1'b0}}};

    function automatic logic signed [DW-1:0] sat_word(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (x > hi)
            return SAT_POS;
        else if (x < lo)
            return SAT_NEG;
        else
            return x[DW-1:0];
    endfunction

    // Heaviside in units of half: 0 outside, 1 on the surface, 2 inside.
    function automatic logic signed [2:0] h_code(input logic signed [DW-1:0] d);
        if (d == '0)
            return 3'sd1;
        else if (d[DW-1])
            return 3'sd0;
        else
            return 3'sd2;
    endfunction

    logic [REGW-1:0]   spacing_h_reg;
    logic [REGW-1:0]   inv_two_h_reg;
    logic [REGW-1:0]   half_h_squared_reg;

    logic              adv;
    logic [5:0]        v_reg;
    s1_t               s1_reg, s1_next;
    s2_t               s2_reg, s2_next;
    s3_t               s3_reg, s3_next;
    s4_t               s4_reg, s4_next;
    s5_t               s5_reg, s5_next;
    logic [63:0]       nh_reg, nh_next;
    logic [63:0]       nd_reg, nd_next;
    logic [DENW-1:0]   den6_reg;
    side_t             side6_reg, side6_next;

    logic              div_valid;
    div_stage_t        div_out;

    logic              out_valid_reg;
    logic [191:0]      out_data_reg, out_data_next;
    logic              out_user_reg, out_user_next;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_h_reg      <= REGW'(65536);
            inv_two_h_reg      <= REGW'(32768);
            half_h_squared_reg <= REGW'(32768);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SPACING_H: spacing_h_reg      <= cfg_data;
                REG_INV_TWO_H: inv_two_h_reg      <= cfg_data;
                REG_HALF_H_SQ: half_h_squared_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Stage 1: near/far test and neighbour differences.
    always_comb
    begin
        logic signed [DW-1:0] c;
        logic signed [DW-1:0] dp;
        logic signed [DW-1:0] dm;
        logic signed [DW-1:0] ip;
        logic signed [DW-1:0] im;
        logic signed [DW+1:0] c_ext;
        logic signed [DW+1:0] th_ext;
        c      = s_tdata[DW-1:0];
        c_ext  = {{2{c[DW-1]}}, c};
        th_ext = {2'b00, spacing_h_reg, 1'b0};
        s1_next.far        = (c_ext > th_ext) || (c_ext < -th_ext);
        s1_next.far_inside = !c[DW-1] && (c != '0);
        s1_next.prior      = s_tdata[255:224];
        for (int k = 0; k < 3; k++)
        begin
            dp = s_tdata[DW + 2*DW*k +: DW];
            dm = s_tdata[2*DW + 2*DW*k +: DW];
            ip = dp[DW-1] ? '0 : dp;
            im = dm[DW-1] ? '0 : dm;
            s1_next.dd[k] = {dp[DW-1], dp} - {dm[DW-1], dm};
            s1_next.di[k] = {ip[DW-1], ip} - {im[DW-1], im};
            s1_next.gh[k] = h_code(dp) - h_code(dm);
        end
    end

    // Stage 2: scale differences by 1/(2h).
    always_comb
    begin
        logic signed [DW-1:0] inv_s;
        inv_s = {1'b0, inv_two_h_reg};
        s2_next.far        = s1_reg.far;
        s2_next.far_inside = s1_reg.far_inside;
        s2_next.prior      = s1_reg.prior;
        s2_next.gh         = s1_reg.gh;
        for (int k = 0; k < 3; k++)
        begin
            s2_next.pg[k] = 64'(s1_reg.dd[k]) * 64'(inv_s);
            s2_next.pi[k] = 64'(s1_reg.di[k]) * 64'(inv_s);
        end
    end

    // Stage 3: floor to Q16.16 and saturate the gradients.
    always_comb
    begin
        s3_next.far        = s2_reg.far;
        s3_next.far_inside = s2_reg.far_inside;
        s3_next.prior      = s2_reg.prior;
        s3_next.gh         = s2_reg.gh;
        for (int k = 0; k < 3; k++)
        begin
            s3_next.gu[k] = sat_word(s2_reg.pg[k] >>> FB);
            s3_next.gi[k] = sat_word(s2_reg.pi[k] >>> FB);
        end
    end

    // Stage 4: the three products per axis. The Heaviside difference is in
    // halves, so its product is later floored by one bit instead of FB.
    always_comb
    begin
        s4_next.far        = s3_reg.far;
        s4_next.far_inside = s3_reg.far_inside;
        s4_next.prior      = s3_reg.prior;
        s4_next.gu         = s3_reg.gu;
        for (int k = 0; k < 3; k++)
        begin
            s4_next.puu[k] = 64'(s3_reg.gu[k]) * 64'(s3_reg.gu[k]);
            s4_next.pih[k] = 64'(s3_reg.gi[k]) * 64'(s3_reg.gu[k]);
            s4_next.phd[k] = 35'(s3_reg.gh[k]) * 35'(s3_reg.gu[k]);
        end
    end

    // Stage 5: floor each product and sum.
    always_comb
    begin
        logic signed [63:0] t;
        logic signed [34:0] td;
        s5_next.far        = s4_reg.far;
        s5_next.far_inside = s4_reg.far_inside;
        s5_next.prior      = s4_reg.prior;
        s5_next.gu         = s4_reg.gu;
        s5_next.den        = DENW'(1);
        s5_next.num_h      = '0;
        s5_next.num_d      = '0;
        for (int k = 0; k < 3; k++)
        begin
            t             = s4_reg.puu[k] >>> FB;
            s5_next.den   = s5_next.den + t[DENW-1:0];
            t             = s4_reg.pih[k] >>> FB;
            s5_next.num_h = s5_next.num_h + t[DENW:0];
            td            = s4_reg.phd[k] >>> 1;
            s5_next.num_d = s5_next.num_d + td;
        end
    end

    // Stage 6: magnitudes and the two dividends.
    always_comb
    begin
        logic [DENW:0] mag_h;
        logic [34:0]   mag_d;
        mag_h   = s5_reg.num_h[DENW] ? (DENW+1)'(-s5_reg.num_h) : s5_reg.num_h;
        mag_d   = s5_reg.num_d[34]   ? 35'(-s5_reg.num_d)       : s5_reg.num_d;
        nh_next = {mag_h[DENW-1:0], {FB{1'b0}}};
        nd_next = {33'b0, half_h_squared_reg} * {29'b0, mag_d};
        side6_next.far        = s5_reg.far;
        side6_next.far_inside = s5_reg.far_inside;
        side6_next.neg_h      = s5_reg.num_h[DENW];
        side6_next.neg_d      = s5_reg.num_d[34];
        side6_next.prior      = s5_reg.prior;
        side6_next.gu_x       = s5_reg.gu[0];
        side6_next.gu_y       = s5_reg.gu[1];
        side6_next.gu_z       = s5_reg.gu[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[4:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            s3_reg    <= s3_next;
            s4_reg    <= s4_next;
            s5_reg    <= s5_next;
            nh_reg    <= nh_next;
            nd_reg    <= nd_next;
            den6_reg  <= s5_reg.den;
            side6_reg <= side6_next;
        end
    end

    sdfh_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v_reg[5]),
        .den       (den6_reg),
        .num_h     (nh_reg),
        .num_d     (nd_reg),
        .side_in   (side6_reg),
        .out_valid (div_valid),
        .out_stage (div_out)
    );

    // Final stage: sign, saturation and the surface decision.
    always_comb
    begin
        logic [DW-1:0] chi;
        logic [DW-1:0] dq;
        logic [DW-1:0] merged;
        logic          sv;
        side_t         sd;
        sd = div_out.side;
        if (sd.far)
            chi = sd.far_inside ? ONE_FIX : '0;
        else if (sd.neg_h)
            chi = (div_out.ovf_h || div_out.q_h > Q_MAX_NEG) ? SAT_NEG
                                                             : DW'(-div_out.q_h);
        else
            chi = (div_out.ovf_h || div_out.q_h > Q_MAX_POS) ? SAT_POS
                                                             : div_out.q_h[DW-1:0];
        dq = (div_out.ovf_d || div_out.q_d > Q_MAX_POS) ? SAT_POS : div_out.q_d[DW-1:0];
        sv = !sd.far && !sd.neg_d && (div_out.ovf_d || div_out.q_d > QBITS'(1));
        merged = ($signed(chi) > sd.prior) ? chi : sd.prior;
        out_user_next = sv;
        out_data_next = {sv ? sd.gu_z : '0,
                         sv ? sd.gu_y : '0,
                         sv ? sd.gu_x : '0,
                         sv ? dq      : '0,
                         merged,
                         chi};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // A surface point always carries a delta weight above one LSB.
    a_surface_delta: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> $signed(m_tdata[95:64]) > 32'sd1)
        else $error("surface beat without a delta weight above epsilon");

    // Without a surface point the weight and the gradient are all zero.
    a_no_surface_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[191:64] == '0)
        else $error("non-surface beat carries weight or gradient");

    // The merged indicator never falls below this body's indicator.
    a_merge_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[63:32]) >= $signed(m_tdata[31:0]))
        else $error("merged indicator below chi_value");

endmodule

[src/sdfh_div.sv]
// ----------------------------------------------------------------------------
// sdfh_div: pipelined twin restoring divider
// Divides two 64-bit dividends by one shared 48-bit denominator, one
// quotient bit per stage, and flags quotients that need more than 33 bits.
// ----------------------------------------------------------------------------
module sdfh_div
    import sdfh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DENW-1:0]  den,
    input  logic [63:0]      num_h,
    input  logic [63:0]      num_d,
    input  side_t            side_in,
    output logic             out_valid,
    output div_stage_t       out_stage
);

    div_stage_t             stage_reg [0:QBITS];
    div_stage_t             stage_next [0:QBITS];
    logic [QBITS:0]         valid_reg;

    // Load stage: the bits above the quotient window form the first remainder.
    always_comb
    begin
        stage_next[0].den   = den;
        stage_next[0].rem_h = {{(DENW-31){1'b0}}, num_h[63:QBITS]};
        stage_next[0].rem_d = {{(DENW-31){1'b0}}, num_d[63:QBITS]};
        stage_next[0].low_h = num_h[QBITS-1:0];
        stage_next[0].low_d = num_d[QBITS-1:0];
        stage_next[0].q_h   = '0;
        stage_next[0].q_d   = '0;
        stage_next[0].ovf_h = {{(DENW-31){1'b0}}, num_h[63:QBITS]} >= den;
        stage_next[0].ovf_d = {{(DENW-31){1'b0}}, num_d[63:QBITS]} >= den;
        stage_next[0].side  = side_in;
    end

    for (genvar j = 0; j < QBITS; j++)
    begin : g_step
        logic [DENW:0] t_h;
        logic [DENW:0] t_d;
        logic          ge_h;
        logic          ge_d;

        always_comb
        begin
            t_h  = {stage_reg[j].rem_h, stage_reg[j].low_h[QBITS-1]};
            t_d  = {stage_reg[j].rem_d, stage_reg[j].low_d[QBITS-1]};
            ge_h = t_h >= {1'b0, stage_reg[j].den};
            ge_d = t_d >= {1'b0, stage_reg[j].den};
            stage_next[j+1]       = stage_reg[j];
            stage_next[j+1].rem_h = ge_h ? DENW'(t_h - {1'b0, stage_reg[j].den})
                                         : t_h[DENW-1:0];
            stage_next[j+1].rem_d = ge_d ? DENW'(t_d - {1'b0, stage_reg[j].den})
                                         : t_d[DENW-1:0];
            stage_next[j+1].low_h = {stage_reg[j].low_h[QBITS-2:0], 1'b0};
            stage_next[j+1].low_d = {stage_reg[j].low_d[QBITS-2:0], 1'b0};
            stage_next[j+1].q_h   = {stage_reg[j].q_h[QBITS-2:0], ge_h};
            stage_next[j+1].q_d   = {stage_reg[j].q_d[QBITS-2:0], ge_d};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[QBITS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= QBITS; i++)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign out_valid = valid_reg[QBITS];
    assign out_stage = stage_reg[QBITS];

endmodule

[dv/sdfh_checker.sv]
// ----------------------------------------------------------------------------
// sdfh_checker: prediction and comparison for the smoothed Heaviside block
// Watches the input, output and register channels. For every accepted input
// beat it computes the expected indicator, delta weight and gradient. It
// compares every output beat, field by field, with the oldest expectation.
// ----------------------------------------------------------------------------
module sdfh_checker
    import sdfh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [255:0]     s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [191:0]     m_tdata,
    input  logic             m_tuser,
    input  logic             cfg_we,
    input  cfg_index_t       cfg_index,
    input  logic [REGW-1:0]  cfg_data,
    output int               fail_count,
    output int               outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] chi;
        logic signed [31:0] merged;
        logic               surface;
        logic signed [31:0] delta;
        logic signed [31:0] grad [3];
    } cell_result_t;

    cell_result_t cell_queue [$];
    longint spacing, inv_2h, half_hsq;

    assign outstanding = cell_queue.size();

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint signed_from_mag(bit neg, longint unsigned mag);
        if (neg) return (mag > 64'd2147483648) ? -64'sd2147483648 : -longint'(mag);
        return (mag > 64'd2147483647) ? 64'sd2147483647 : longint'(mag);
    endfunction

    function automatic longint step_of(longint d);
        if (d == 0) return 64'sd32768;
        return (d < 0) ? 64'sd0 : 64'sd65536;
    endfunction

    function automatic cell_result_t predict_cell(logic [255:0] beat);
        longint c, prior, two_h, chi, delta, den, num_h, num_d;
        longint dp, dm, ip, im, gi, gh;
        longint gu [3];
        longint unsigned q, mag;
        cell_result_t r;
        c     = longint'($signed(beat[31:0]));
        prior = longint'($signed(beat[255:224]));
        two_h = spacing * 2;
        delta = 0;
        r.surface = 1'b0;
        for (int k = 0; k < 3; k++) r.grad[k] = '0;
        if (c > two_h || c < -two_h) begin
            chi = (c > 0) ? 64'sd65536 : 64'sd0;
        end
        else begin
            den = 1;
            num_h = 0;
            num_d = 0;
            for (int k = 0; k < 3; k++) begin
                dp = longint'($signed(beat[32*(2*k+1) +: 32]));
                dm = longint'($signed(beat[32*(2*k+2) +: 32]));
                ip = (dp < 0) ? 0 : dp;
                im = (dm < 0) ? 0 : dm;
                gu[k] = sat32(((dp - dm) * inv_2h) >>> 16);
                gi    = sat32(((ip - im) * inv_2h) >>> 16);
                gh    = step_of(dp) - step_of(dm);
                den   += (gu[k] * gu[k]) >>> 16;
                num_h += (gi * gu[k]) >>> 16;
                num_d += (gh * gu[k]) >>> 16;
            end
            mag = (num_h < 0) ? longint'(-num_h) : longint'(num_h);
            q = (mag << 16) / longint'(den);
            chi = signed_from_mag(num_h < 0, q);
            mag = (num_d < 0) ? longint'(-num_d) : longint'(num_d);
            q = (longint'(half_hsq) * mag) / longint'(den);
            delta = signed_from_mag(num_d < 0, q);
            if (delta > 1) begin
                r.surface = 1'b1;
                for (int k = 0; k < 3; k++) r.grad[k] = gu[k][31:0];
            end
            else begin
                delta = 0;
            end
        end
        r.chi    = chi[31:0];
        r.merged = (chi > prior) ? chi[31:0] : prior[31:0];
        r.delta  = delta[31:0];
        return r;
    endfunction

    task automatic compare_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t e;
        if (!rst_n) begin
            spacing    = 65536;
            inv_2h     = 32768;
            half_hsq   = 32768;
            fail_count = 0;
            cell_queue.delete();
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (cell_queue.size() == 0) begin
                    $error("output beat with no input waiting for it");
                    fail_count++;
                end
                else begin
                    e = cell_queue.pop_front();
                    compare_field("chi_value", e.chi, $signed(m_tdata[31:0]));
                    compare_field("merged_chi", e.merged, $signed(m_tdata[63:32]));
                    compare_field("delta_weight", e.delta, $signed(m_tdata[95:64]));
                    compare_field("grad_x", e.grad[0], $signed(m_tdata[127:96]));
                    compare_field("grad_y", e.grad[1], $signed(m_tdata[159:128]));
                    compare_field("grad_z", e.grad[2], $signed(m_tdata[191:160]));
                    compare_field("surface_valid", e.surface, m_tuser);
                end
            end
            if (s_tvalid && s_tready) cell_queue.push_back(predict_cell(s_tdata));
            if (cfg_we) begin
                case (cfg_index)
                    REG_SPACING_H: spacing  = cfg_data;
                    REG_INV_TWO_H: inv_2h   = cfg_data;
                    REG_HALF_H_SQ: half_hsq = cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

[dv/tb_sdf_to_smoothed_heaviside.sv]
// ----------------------------------------------------------------------------
// tb_sdf_to_smoothed_heaviside: stimulus and verdict for the Heaviside block
// Streams directed and random cells through the block under several grid
// spacings, with bursty input and a stalling output. A checker alongside
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sdf_to_smoothed_heaviside;

    import sdfh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1840;
    localparam int N_PHASES = 7;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [255:0]     s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [191:0]     m_tdata;
    logic             m_tuser;
    logic             cfg_we = 1'b0;
    cfg_index_t       cfg_index = REG_SPACING_H;
    logic [REGW-1:0]  cfg_data = '0;
    int               fail_count;
    int               outstanding;

    longint           cur_h = 65536;
    int               stall_mode = 0;

    // Register sets per phase: spacing, one over twice the spacing, half h squared.
    longint phase_regs [N_PHASES][3] = '{
        '{65536, 32768, 32768},
        '{16384, 131072, 2048},
        '{4096, 524288, 128},
        '{262144, 8192, 524288},
        '{2147483647, 2147483647, 2147483647},
        '{1, 1, 0},
        '{1, 2147483647, 1}
    };

    always #1 clk = ~clk;

    sdf_to_smoothed_heaviside dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    sdfh_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    // The receiver switches now and then between always ready, random stalls
    // and long stall spells.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    function automatic logic [31:0] clamp32(longint x);
        if (x > 64'sd2147483647) return 32'h7fffffff;
        if (x < -64'sd2147483648) return 32'h80000000;
        return x[31:0];
    endfunction

    function automatic longint rand_span(longint lim);
        longint unsigned r;
        r = {$urandom, $urandom};
        return longint'(r % longint'(2 * lim + 1)) - lim;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Mostly cells in the band around the surface, neighbours scattered about
    // the centre so that signs and exact zeros mix; the rest is full-range noise.
    function automatic logic [255:0] rand_cell();
        logic [255:0] d;
        longint c;
        if ($urandom_range(0, 5) == 0) begin
            for (int k = 0; k < 8; k++) d[32*k +: 32] = rand_word();
            return d;
        end
        c = rand_span(2 * cur_h);
        d[31:0] = clamp32(c);
        for (int k = 1; k < 7; k++) begin
            case ($urandom_range(0, 7))
                0: d[32*k +: 32] = '0;
                1: d[32*k +: 32] = rand_word();
                default: d[32*k +: 32] = clamp32(c + rand_span(2 * cur_h + 4));
            endcase
        end
        d[255:224] = ($urandom_range(0, 1) == 1) ? rand_word() : clamp32(rand_span(65536));
        return d;
    endfunction

    task automatic send_cell(logic [255:0] d);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic idle_sender(int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        idle_sender(1);
        while (outstanding != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_regs(int p);
        for (int i = 0; i < 3; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data  <= phase_regs[p][i][REGW-1:0];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_h = phase_regs[p][0];
    endtask

    initial
    begin
        logic [255:0] d;
        int burst;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed cells under the reset spacing of 1.0.
        send_cell({8{32'h7fffffff}});
        send_cell({8{32'h80000000}});
        send_cell('0);
        send_cell({32'h80000000, {6{32'h00000000}}, 32'h00020000});
        send_cell({32'h7fffffff, {6{32'h00000000}}, 32'hfffe0000});
        send_cell({32'h0, {6{32'h00000000}}, 32'h00020001});
        send_cell({32'h0, {6{32'h00000000}}, 32'hfffdffff});
        send_cell({32'h0, 32'hffff0000, 32'h00010000, 32'hffff0000, 32'h00010000,
                   32'hffff0000, 32'h00010000, 32'h0});
        send_cell({32'h0, 32'h00010000, 32'hffff0000, 32'h00010000, 32'hffff0000,
                   32'h00010000, 32'hffff0000, 32'h0});
        send_cell({32'h00008000, 32'h0, 32'h00010000, 32'h0, 32'h00010000,
                   32'h0, 32'h00010000, 32'h0});
        send_cell({32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   32'h80000000, 32'h7fffffff, 32'h0});
        send_cell({32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                   32'h7fffffff, 32'h80000000, 32'h0});
        send_cell({32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00000001, 32'hffffffff,
                   32'h00000000});
        send_cell({32'h0, 32'h00020000, 32'hfffe0000, 32'h00008000, 32'hffff8000,
                   32'h0, 32'h0, 32'hffffffff});

        // Random cells over every register set; the sender pauses for the
        // pipe to drain at each change of spacing.
        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                drain();
                write_regs(p);
            end
            for (int i = 0; i < N_RANDOM / N_PHASES; i += burst) begin
                burst = $urandom_range(1, 40);
                for (int b = 0; b < burst; b++) begin
                    d = rand_cell();
                    send_cell(d);
                end
                if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
            end
        end
        drain();
        write_regs(0);
        for (int i = 0; i < 10; i++) send_cell(rand_cell());
        drain();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
src/sdfh_pkg.sv
src/sdfh_div.sv
src/sdf_to_smoothed_heaviside.sv
dv/sdfh_checker.sv
dv/tb_sdf_to_smoothed_heaviside.sv
